FILE: sv/kpc_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants for the keypad calculator core.
// Has no dependencies; every other file of the block imports it.
package kpc_pkg;

  localparam int OPERAND_BITS_DEF  = 20;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int CODE_BITS         = 20;
  localparam int VALUE_BITS        = 57;
  localparam int KEY_BITS          = 6;
  localparam int KIND_BITS         = 2;
  localparam int QUEUE_DEPTH       = 2;

  localparam logic [CODE_BITS-1:0] UNLOCK_RESET = 20'd1234;

  // Keypad codes.
  localparam logic [KEY_BITS-1:0] KEY_DIGIT_MAX = 6'd9;
  localparam logic [KEY_BITS-1:0] KEY_SQRT      = 6'd14;
  localparam logic [KEY_BITS-1:0] KEY_EQUALS    = 6'd34;
  localparam logic [KEY_BITS-1:0] KEY_ADD       = 6'd41;
  localparam logic [KEY_BITS-1:0] KEY_SUB       = 6'd42;
  localparam logic [KEY_BITS-1:0] KEY_MUL       = 6'd43;
  localparam logic [KEY_BITS-1:0] KEY_DIV       = 6'd44;
  localparam logic [KEY_BITS-1:0] KEY_CLEAR     = 6'd55;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_ANSWER   = 2'd0,
    KIND_DIV_ZERO = 2'd1,
    KIND_UNLOCKED = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_SQRT = 3'd5
  } op_t;

  // Commands passed from the front end to the arithmetic back end.
  typedef enum logic [2:0] {
    CMD_UNLOCK   = 3'd0,
    CMD_DIV_ZERO = 3'd1,
    CMD_ADD      = 3'd2,
    CMD_SUB      = 3'd3,
    CMD_MUL      = 3'd4,
    CMD_DIV      = 3'd5,
    CMD_SQRT     = 3'd6
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_DIV,
    BK_SQRT,
    BK_OUT
  } bk_state_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

FILE: sv/kpc_front.sv
`timescale 1ns / 1ps
// Key decoder of the keypad calculator: lock state, operand entry and operator.
// Depends on kpc_pkg; issues commands into kpc_fifo.
module kpc_front #(
  parameter int OPERAND_BITS = kpc_pkg::OPERAND_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [kpc_pkg::KEY_BITS-1:0]   in_key_code,
  input  logic                           cfg_wr_en,
  input  logic [kpc_pkg::CODE_BITS-1:0]  cfg_wr_data,
  input  kpc_pkg::fifo_status_t          q_status,
  output logic                           push,
  output kpc_pkg::cmd_t                  push_cmd,
  output logic [OPERAND_BITS-1:0]        push_a,
  output logic [OPERAND_BITS-1:0]        push_b
);
  import kpc_pkg::*;

  localparam int XW   = OPERAND_BITS + 4;
  localparam int CMPW = (OPERAND_BITS > CODE_BITS) ? OPERAND_BITS : CODE_BITS;

  logic                    unlocked_r, unlocked_nxt;
  logic [OPERAND_BITS-1:0] a_r, a_nxt, b_r, b_nxt;
  op_t                     op_r, op_nxt;
  logic [CODE_BITS-1:0]    code_r;

  logic                    accept, is_digit, match;
  logic [OPERAND_BITS-1:0] digit_src, digit_sat, lock_operand;
  logic [XW-1:0]           digit_ext, digit_sum;

  assign in_stall = q_status.full;
  assign accept   = in_valid && !q_status.full;
  assign is_digit = in_key_code <= KEY_DIGIT_MAX;

  // Times ten plus the digit, saturating at the all-ones operand.
  assign digit_src = (unlocked_r && op_r != OP_NONE) ? b_r : a_r;
  assign digit_ext = XW'(digit_src);
  assign digit_sum = (digit_ext << 3) + (digit_ext << 1) + XW'(in_key_code);
  assign digit_sat = (|digit_sum[XW-1:OPERAND_BITS]) ? '1 : digit_sum[OPERAND_BITS-1:0];

  assign lock_operand = is_digit ? digit_sat : a_r;
  assign match        = CMPW'(lock_operand) == CMPW'(code_r);

  always_comb begin
    unlocked_nxt = unlocked_r;
    a_nxt        = a_r;
    b_nxt        = b_r;
    op_nxt       = op_r;
    push         = 1'b0;
    push_cmd     = CMD_UNLOCK;
    push_a       = a_r;
    push_b       = b_r;
    if (accept) begin
      if (!unlocked_r) begin
        a_nxt = lock_operand;
        if (match || in_key_code == KEY_CLEAR) begin
          a_nxt  = '0;
          b_nxt  = '0;
          op_nxt = OP_NONE;
        end
        if (match) begin
          unlocked_nxt = 1'b1;
          push         = 1'b1;
          push_cmd     = CMD_UNLOCK;
        end
      end else if (is_digit) begin
        if (op_r != OP_NONE) begin
          b_nxt = digit_sat;
        end else begin
          a_nxt = digit_sat;
        end
      end else begin
        case (in_key_code)
          KEY_ADD:  op_nxt = OP_ADD;
          KEY_SUB:  op_nxt = OP_SUB;
          KEY_MUL:  op_nxt = OP_MUL;
          KEY_DIV:  op_nxt = OP_DIV;
          KEY_SQRT: op_nxt = OP_SQRT;
          KEY_CLEAR: begin
            a_nxt  = '0;
            b_nxt  = '0;
            op_nxt = OP_NONE;
          end
          KEY_EQUALS: begin
            if (op_r != OP_NONE) begin
              push = 1'b1;
              unique case (op_r)
                OP_ADD:  push_cmd = CMD_ADD;
                OP_SUB:  push_cmd = CMD_SUB;
                OP_MUL:  push_cmd = CMD_MUL;
                OP_DIV:  push_cmd = (b_r == '0) ? CMD_DIV_ZERO : CMD_DIV;
                OP_SQRT: push_cmd = CMD_SQRT;
                default: push_cmd = CMD_ADD;
              endcase
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unlocked_r <= 1'b0;
      a_r        <= '0;
      b_r        <= '0;
      op_r       <= OP_NONE;
      code_r     <= UNLOCK_RESET;
    end else begin
      unlocked_r <= unlocked_nxt;
      a_r        <= a_nxt;
      b_r        <= b_nxt;
      op_r       <= op_nxt;
      if (cfg_wr_en) begin
        code_r <= cfg_wr_data;
      end
    end
  end

endmodule

FILE: sv/kpc_fifo.sv
`timescale 1ns / 1ps
// Short command queue between the key decoder and the arithmetic unit.
// Depends on kpc_pkg for the status struct; head entry is visible while not empty.
module kpc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = kpc_pkg::QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  logic [WIDTH-1:0]      wdata,
  input  logic                  pop,
  output logic [WIDTH-1:0]      rdata,
  output kpc_pkg::fifo_status_t status
);
  import kpc_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign status.full  = count_r == CW'(DEPTH);
  assign status.empty = count_r == '0;
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign rdata        = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

FILE: sv/kpc_back.sv
`timescale 1ns / 1ps
// Arithmetic unit: add, subtract, registered multiply, bit-serial divide and
// square root, and the output register. Depends on kpc_pkg; fed by kpc_fifo.
module kpc_back #(
  parameter int OPERAND_BITS  = kpc_pkg::OPERAND_BITS_DEF,
  parameter int FRACTION_BITS = kpc_pkg::FRACTION_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  kpc_pkg::fifo_status_t               q_status,
  output logic                                pop,
  input  kpc_pkg::cmd_t                       cmd,
  input  logic [OPERAND_BITS-1:0]             cmd_a,
  input  logic [OPERAND_BITS-1:0]             cmd_b,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [kpc_pkg::KIND_BITS-1:0]       out_result_kind,
  output logic signed [kpc_pkg::VALUE_BITS-1:0] out_result_value
);
  import kpc_pkg::*;

  localparam int OB   = OPERAND_BITS;
  localparam int FB   = FRACTION_BITS;
  localparam int DW   = OB + FB;             // dividend and quotient width
  localparam int RH   = (OB + 1) / 2 + FB;   // root width, one bit per step
  localparam int RW2  = 2 * RH;              // radicand width, padded to even
  localparam int CNTW = $clog2(DW + 1);

  bk_state_t state_r, state_nxt;

  logic [OB-1:0]         a_r, a_nxt, b_r, b_nxt;
  logic [DW-1:0]         quo_r, quo_nxt;
  logic [OB-1:0]         rem_r, rem_nxt;
  logic [RW2-1:0]        rad_r, rad_nxt;
  logic [RH-1:0]         root_r, root_nxt;
  logic [RH+1:0]         srem_r, srem_nxt;
  logic [CNTW-1:0]       cnt_r, cnt_nxt;
  kind_t                 kind_r, kind_nxt;
  logic [VALUE_BITS-1:0] res_r, res_nxt;

  logic                  out_valid_r, out_valid_nxt, load_out;
  kind_t                 out_kind_r;
  logic [VALUE_BITS-1:0] out_value_r;

  logic [OB:0]     sub_diff, add_sum;
  logic [2*OB-1:0] prod;
  logic [OB:0]     div_shift, div_sub;
  logic            div_ge;
  logic [RH+3:0]   sq_pre, sq_trial, sq_sub;
  logic            sq_ge;
  logic            last_step;

  assign add_sum  = {1'b0, cmd_a} + {1'b0, cmd_b};
  assign sub_diff = {1'b0, cmd_a} - {1'b0, cmd_b};
  assign prod     = (2*OB)'(a_r) * (2*OB)'(b_r);

  // Restoring division step: one quotient bit a cycle.
  assign div_shift = {rem_r, quo_r[DW-1]};
  assign div_ge    = div_shift >= {1'b0, b_r};
  assign div_sub   = div_shift - {1'b0, b_r};

  // Digit-by-digit square root step: two radicand bits, one root bit.
  assign sq_pre   = {srem_r, rad_r[RW2-1 -: 2]};
  assign sq_trial = (RH + 4)'({root_r, 2'b01});
  assign sq_ge    = sq_pre >= sq_trial;
  assign sq_sub   = sq_pre - sq_trial;

  assign last_step = cnt_r == CNTW'(1);

  always_comb begin
    state_nxt = state_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    rad_nxt   = rad_r;
    root_nxt  = root_r;
    srem_nxt  = srem_r;
    cnt_nxt   = cnt_r;
    kind_nxt  = kind_r;
    res_nxt   = res_r;
    pop       = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_status.empty) begin
          pop      = 1'b1;
          a_nxt    = cmd_a;
          b_nxt    = cmd_b;
          kind_nxt = KIND_ANSWER;
          res_nxt  = '0;
          unique case (cmd)
            CMD_UNLOCK: begin
              kind_nxt  = KIND_UNLOCKED;
              state_nxt = BK_OUT;
            end
            CMD_DIV_ZERO: begin
              kind_nxt  = KIND_DIV_ZERO;
              state_nxt = BK_OUT;
            end
            CMD_ADD: begin
              res_nxt   = VALUE_BITS'(add_sum) << FB;
              state_nxt = BK_OUT;
            end
            CMD_SUB: begin
              res_nxt   = VALUE_BITS'($signed(sub_diff)) << FB;
              state_nxt = BK_OUT;
            end
            CMD_MUL: state_nxt = BK_MUL;
            CMD_DIV: begin
              quo_nxt   = DW'(cmd_a) << FB;
              rem_nxt   = '0;
              cnt_nxt   = CNTW'(DW);
              state_nxt = BK_DIV;
            end
            CMD_SQRT: begin
              rad_nxt   = RW2'(cmd_b) << (2 * FB);
              srem_nxt  = '0;
              root_nxt  = '0;
              cnt_nxt   = CNTW'(RH);
              state_nxt = BK_SQRT;
            end
            default: state_nxt = BK_IDLE;
          endcase
        end
      end
      BK_MUL: begin
        res_nxt   = VALUE_BITS'(prod) << FB;
        state_nxt = BK_OUT;
      end
      BK_DIV: begin
        rem_nxt = div_ge ? div_sub[OB-1:0] : div_shift[OB-1:0];
        quo_nxt = {quo_r[DW-2:0], div_ge};
        cnt_nxt = cnt_r - 1'b1;
        if (last_step) begin
          res_nxt   = VALUE_BITS'({quo_r[DW-2:0], div_ge});
          state_nxt = BK_OUT;
        end
      end
      BK_SQRT: begin
        srem_nxt = sq_ge ? sq_sub[RH+1:0] : sq_pre[RH+1:0];
        root_nxt = {root_r[RH-2:0], sq_ge};
        rad_nxt  = rad_r << 2;
        cnt_nxt  = cnt_r - 1'b1;
        if (last_step) begin
          res_nxt   = VALUE_BITS'({root_r[RH-2:0], sq_ge});
          state_nxt = BK_OUT;
        end
      end
      BK_OUT: begin
        if (!out_valid_r || !out_stall) begin
          load_out  = 1'b1;
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase

    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    rad_r  <= rad_nxt;
    root_r <= root_nxt;
    srem_r <= srem_nxt;
    kind_r <= kind_nxt;
    res_r  <= res_nxt;
    if (load_out) begin
      out_kind_r  <= kind_r;
      out_value_r <= res_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_kind  = out_kind_r;
  assign out_result_value = out_value_r;

endmodule

FILE: sv/keypad_calculator_core.sv
`timescale 1ns / 1ps
// Keypad calculator core: key decoder, command queue and arithmetic unit.
// Depends on kpc_pkg, kpc_front, kpc_fifo and kpc_back.
//
// Usage. Each request on the input channel carries one keypad code. A
// request is taken at a rising edge with in_valid high and in_stall low.
// Keys that produce a result (the correct unlock code, or equals with an
// operator selected) post a command to a two-entry queue; all other keys
// only update the operands, the operator or the lock state.
// Results leave through an output register: out_valid stays high with a
// steady payload until out_stall is low at a rising edge.
// A key that posts a command is written into the queue, and the arithmetic
// unit then pops it. Unlock, divide-by-zero, add and subtract go straight
// to the output state, multiply first passes through BK_MUL, divide works
// one quotient bit a cycle and square root one root bit a cycle, and the
// output state loads the output register. Throughput is one key a cycle
// while the queue has room; the arithmetic unit takes one command at a
// time and starts the next only once its result is loaded for output.
// Reset (rst_n low at a rising edge) locks the calculator, clears the
// operands, operator, queue and out_valid flag, and restores the unlock
// code to 1234. A stalled receiver first holds the output register, then
// the arithmetic unit, and once the queue is full in_stall rises.
module keypad_calculator_core #(
  parameter int OPERAND_BITS  = kpc_pkg::OPERAND_BITS_DEF,
  parameter int FRACTION_BITS = kpc_pkg::FRACTION_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [kpc_pkg::KEY_BITS-1:0]          in_key_code,
  input  logic                                  cfg_wr_en,
  input  logic [kpc_pkg::CODE_BITS-1:0]         cfg_wr_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [kpc_pkg::KIND_BITS-1:0]         out_result_kind,
  output logic signed [kpc_pkg::VALUE_BITS-1:0] out_result_value
);
  import kpc_pkg::*;

  // A queue entry holds the command code followed by both operands.
  localparam int CMD_W = $bits(cmd_t);
  localparam int QW    = CMD_W + 2 * OPERAND_BITS;

  fifo_status_t            q_status;
  logic                    q_push, q_pop;
  cmd_t                    push_cmd, head_cmd;
  logic [OPERAND_BITS-1:0] push_a, push_b, head_a, head_b;
  logic [QW-1:0]           q_wdata, q_rdata;

  // The front end decodes every key in the cycle it is taken.
  kpc_front #(
    .OPERAND_BITS (OPERAND_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_key_code (in_key_code),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_status    (q_status),
    .push        (q_push),
    .push_cmd    (push_cmd),
    .push_a      (push_a),
    .push_b      (push_b)
  );

  assign q_wdata = {push_cmd, push_a, push_b};

  kpc_fifo #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .pop    (q_pop),
    .rdata  (q_rdata),
    .status (q_status)
  );

  assign head_cmd = cmd_t'(q_rdata[QW-1 -: CMD_W]);
  assign head_a   = q_rdata[2*OPERAND_BITS-1 -: OPERAND_BITS];
  assign head_b   = q_rdata[OPERAND_BITS-1:0];

  // The back end works on one command at a time and owns the output register.
  kpc_back #(
    .OPERAND_BITS  (OPERAND_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_status         (q_status),
    .pop              (q_pop),
    .cmd              (head_cmd),
    .cmd_a            (head_a),
    .cmd_b            (head_b),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_kind  (out_result_kind),
    .out_result_value (out_result_value)
  );

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for keypad_calculator_core: locked and unlocked key handling.
// Depends on kpc_pkg and the keypad_calculator_core RTL only.
module testbench;
  import kpc_pkg::*;

  localparam int OPERAND_BITS  = OPERAND_BITS_DEF;
  localparam int FRACTION_BITS = FRACTION_BITS_DEF;
  localparam longint unsigned OPERAND_MAX = (64'd1 << OPERAND_BITS) - 64'd1;
  localparam logic [CODE_BITS-1:0] CODE_MAX = '1;
  localparam logic [KEY_BITS-1:0] KEY_UNUSED_TOP = '1;

  // The slowest request is a divide, and this many idle cycles outlast
  // it, so they leave the core truly quiet.
  localparam int DRAIN_CYCLES = 60;
  // At least PHASES * KEYS_PER_PHASE (1600) keys, each costing at most a divide,
  // a long output stall and a sender gap, taken several times over.
  localparam int CYCLE_LIMIT = 800000;
  localparam int KEYS_PER_PHASE = 400;
  localparam int PHASES = 4;

  typedef struct {
    logic [KIND_BITS-1:0]  kind;
    logic [VALUE_BITS-1:0] value;
  } answer_t;

  // Tracks the calculator's state as keys are accepted and holds the
  // answers that the core still owes, oldest first.
  class answer_board;
    logic [CODE_BITS-1:0]    code;
    bit                      unlocked;
    logic [OPERAND_BITS-1:0] lhs;
    logic [OPERAND_BITS-1:0] rhs;
    op_t                     op;
    answer_t                 awaited[$];
    int                      errors;

    function new();
      code = UNLOCK_RESET;
      unlocked = 1'b0;
      errors = 0;
      clear_all();
    endfunction

    function void clear_all();
      lhs = '0;
      rhs = '0;
      op = OP_NONE;
    endfunction

    function void set_code(logic [CODE_BITS-1:0] v);
      code = v;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    // Decimal entry saturates at the largest operand rather than wrapping.
    function logic [OPERAND_BITS-1:0] append_digit(logic [OPERAND_BITS-1:0] v,
                                                   logic [KEY_BITS-1:0] d);
      longint unsigned n;
      n = 64'(v) * 64'd10 + 64'(d);
      if (n > OPERAND_MAX) n = OPERAND_MAX;
      return n[OPERAND_BITS-1:0];
    endfunction

    function longint unsigned floor_root(longint unsigned x);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int i = 31; i >= 0; i--) begin
        trial = root | (64'd1 << i);
        if (trial * trial <= x) root = trial;
      end
      return root;
    endfunction

    function void owe(logic [KIND_BITS-1:0] kind, logic [VALUE_BITS-1:0] value);
      answer_t a;
      a.kind = kind;
      a.value = value;
      awaited.push_back(a);
    endfunction

    function void note_key(logic [KEY_BITS-1:0] k);
      bit                    hit;
      logic [VALUE_BITS-1:0] a;
      logic [VALUE_BITS-1:0] b;
      logic [VALUE_BITS-1:0] v;
      if (!unlocked) begin
        // The code is compared after every key, and a clear only takes
        // effect once the comparison has seen the old operand.
        if (k <= KEY_DIGIT_MAX) lhs = append_digit(lhs, k);
        hit = (64'(lhs) == 64'(code));
        if (k == KEY_CLEAR) clear_all();
        if (hit) begin
          unlocked = 1'b1;
          clear_all();
          owe(KIND_UNLOCKED, '0);
        end
        return;
      end
      case (k)
        KEY_ADD:   op = OP_ADD;
        KEY_SUB:   op = OP_SUB;
        KEY_MUL:   op = OP_MUL;
        KEY_DIV:   op = OP_DIV;
        KEY_SQRT:  op = OP_SQRT;
        KEY_CLEAR: begin
          clear_all();
          return;
        end
        default: ;
      endcase
      if (k <= KEY_DIGIT_MAX) begin
        if (op != OP_NONE) rhs = append_digit(rhs, k);
        else lhs = append_digit(lhs, k);
        return;
      end
      if (k != KEY_EQUALS || op == OP_NONE) return;
      a = VALUE_BITS'(lhs);
      b = VALUE_BITS'(rhs);
      case (op)
        OP_ADD: v = (a + b) << FRACTION_BITS;
        OP_SUB: v = (a - b) << FRACTION_BITS;
        OP_MUL: v = (a * b) << FRACTION_BITS;
        OP_DIV: begin
          if (b == '0) begin
            owe(KIND_DIV_ZERO, '0);
            return;
          end
          v = (a << FRACTION_BITS) / b;
        end
        default: v = VALUE_BITS'(floor_root(64'(rhs) << (2 * FRACTION_BITS)));
      endcase
      owe(KIND_ANSWER, v);
    endfunction

    function void check_answer(logic [KIND_BITS-1:0] kind, logic [VALUE_BITS-1:0] value);
      answer_t want;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result, expected none, got kind %0d value %0d",
                 $time, kind, $signed(value));
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (kind !== want.kind) begin
        $display("%0t: result_kind expected %0d, got %0d", $time, want.kind, kind);
        errors++;
      end
      if (value !== want.value) begin
        $display("%0t: result_value expected %0d, got %0d", $time,
                 $signed(want.value), $signed(value));
        errors++;
      end
    endfunction
  endclass

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [KEY_BITS-1:0]          in_key_code = '0;
  logic                         cfg_wr_en = 1'b0;
  logic [CODE_BITS-1:0]         cfg_wr_data = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [KIND_BITS-1:0]         out_result_kind;
  logic signed [VALUE_BITS-1:0] out_result_value;

  answer_board book;
  int burst_left = 0;
  int useful_keys = 0;
  int stall_mode = 0;
  int stall_left = 0;
  int cycle_count = 0;

  keypad_calculator_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_key_code      (in_key_code),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_kind  (out_result_kind),
    .out_result_value (out_result_value)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // The run is abandoned if it takes far longer than any correct run could.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // The receiver switches now and then between never stalling, stalling
  // now and again, and stalling most of the time, so that results back up
  // into the arithmetic unit and the command queue.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(20, 300);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 9) < 8);
    endcase
  end

  // Every result taken by the receiver is checked against the oldest
  // answer still owed. All sampling happens at the rising edge, before the
  // core's registers move.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall)
      book.check_answer(out_result_kind, out_result_value);
  end

  // Offers one key and returns at the edge that accepts the request. The
  // sender works in bursts: at the start of each burst it may drop valid
  // for a short gap, and now and then a burst is long enough to run for
  // a good while with no gap at all.
  task automatic push_key(input logic [KEY_BITS-1:0] k);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_key_code <= k;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    book.note_key(k);
    if (k <= KEY_DIGIT_MAX ||
        k inside {KEY_SQRT, KEY_EQUALS, KEY_ADD, KEY_SUB, KEY_MUL, KEY_DIV, KEY_CLEAR})
      useful_keys++;
  endtask

  // Stops sending, waits for every owed result and then lets the core run
  // dry, since keys that owe nothing may still be in flight.
  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (book.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_code(input logic [CODE_BITS-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    book.set_code(v);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic type_digit();
    push_key(KEY_BITS'($urandom_range(0, 9)));
  endtask

  // Operand entry: nothing at all, a run of zeros, or short, middling and
  // long numbers; the long ones push the operand into saturation.
  task automatic type_number();
    case ($urandom_range(0, 5))
      0: ;
      1: repeat ($urandom_range(1, 3)) push_key('0);
      2, 5: repeat ($urandom_range(1, 3)) type_digit();
      3: repeat ($urandom_range(4, 6)) type_digit();
      default: repeat ($urandom_range(7, 8)) type_digit();
    endcase
  endtask

  task automatic pick_operator();
    case ($urandom_range(0, 4))
      0: push_key(KEY_ADD);
      1: push_key(KEY_SUB);
      2: push_key(KEY_MUL);
      3: push_key(KEY_DIV);
      default: push_key(KEY_SQRT);
    endcase
  endtask

  // A well-formed calculation with random content. Sometimes the operator
  // is changed midway, sometimes equals is pressed twice, and operands are
  // only cleared part of the time so that they carry over.
  task automatic run_calculation();
    if ($urandom_range(0, 1) == 0) push_key(KEY_CLEAR);
    type_number();
    pick_operator();
    if ($urandom_range(0, 7) == 0) pick_operator();
    type_number();
    if ($urandom_range(0, 9) == 0) pick_operator();
    push_key(KEY_EQUALS);
    if ($urandom_range(0, 4) == 0) push_key(KEY_EQUALS);
  endtask

  // Noise and broken sequences: any code at all, equals with no operator,
  // and runs of non-digit keys in any order.
  task automatic run_noise();
    case ($urandom_range(0, 2))
      0: push_key(KEY_BITS'($urandom_range(0, 63)));
      1: begin
        push_key(KEY_CLEAR);
        push_key(KEY_EQUALS);
      end
      default: repeat ($urandom_range(1, 4)) push_key(KEY_BITS'($urandom_range(10, 63)));
    endcase
  endtask

  initial begin
    book = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Locked, with the code left at its reset value: operators, equals,
    // square root and unused codes are ignored, and a clear compares the
    // partial entry before wiping it.
    push_key(KEY_BITS'(1));
    push_key(KEY_BITS'(2));
    push_key(KEY_ADD);
    push_key(KEY_EQUALS);
    push_key(KEY_SQRT);
    push_key(KEY_UNUSED_TOP);
    push_key(KEY_CLEAR);
    settle();

    // A zero code: the clear must not unlock, as the entry was five when it
    // was compared. Seven nines then saturate the operand.
    load_code('0);
    push_key(KEY_BITS'(5));
    push_key(KEY_CLEAR);
    repeat (7) push_key(KEY_DIGIT_MAX);
    push_key(KEY_EQUALS);
    settle();

    // The largest code now matches the saturated operand, and an ignored
    // key is enough to trigger the unlock.
    load_code(CODE_MAX);
    push_key(KEY_UNUSED_TOP);

    // Unlocked: divide by zero, then equals with no operator selected.
    push_key(KEY_DIV);
    push_key(KEY_EQUALS);
    push_key(KEY_CLEAR);
    push_key(KEY_EQUALS);

    // Random calculations in phases; the code is rewritten between phases
    // while the core is quiet.
    useful_keys = 0;
    for (int phase = 0; phase < PHASES; phase++) begin
      while (useful_keys < (phase + 1) * KEYS_PER_PHASE) begin
        if ($urandom_range(0, 9) < 8) run_calculation();
        else run_noise();
      end
      settle();
      if (phase < PHASES - 1) load_code(CODE_BITS'($urandom_range(0, CODE_MAX)));
    end

    if (book.errors == 0 && book.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
